// ----- src/mbs_pkg.sv -----
// Shared types, codes and constants of the multipart boundary splitter.
package mbs_pkg;

	localparam int MAX_BOUNDARY_DEF = 62;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_STREAM = 2'd1;
	localparam logic [1:0] ACT_EOS    = 2'd2;

	localparam logic [1:0] KIND_DATA        = 2'd0;
	localparam logic [1:0] KIND_BOUNDARY    = 2'd1;
	localparam logic [1:0] KIND_NO_BOUNDARY = 2'd2;

	localparam logic [7:0] CHAR_DASH = 8'h2D;
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;

	localparam logic [5:0] LENGTH_RESET = 6'd1;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] in_byte;
		logic [5:0] pattern_index;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DRAIN_RD,
		ST_DRAIN_PUSH,
		ST_EOS_HELD,
		ST_EOS_RD,
		ST_EOS_CAP,
		ST_EOS_END
	} ctrl_state_t;

	typedef struct packed {
		logic load_item;
		logic pat_write;
		logic capture;
		logic mismatch_start;
		logic match_done;
		logic push;
		logic push_cap;
		logic push_last;
		logic k_clr;
		logic k_inc;
		logic cap_rd;
		logic drain_end;
		logic eos_held_emit;
		logic eos_cap_emit;
		logic eos_end;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       cap_path;
		logic       finish;
		logic       mismatch_next;
		logic       held_full;
		logic       held_empty;
		logic       out_free;
		logic       k_last;
		logic       cap_active;
	} stat_t;

endpackage

// ----- src/multipart_boundary_splitter.sv -----
// Multipart boundary splitter top level: controller, datapath and checks.
// Each request is taken in IDLE and carried out in EXEC; a data or boundary result is then registered.
// A pattern load or idle action gives no result.
// A mismatched capture drains one captured byte per DRAIN_RD and DRAIN_PUSH pass (capture memory read port).
// End of stream: held bytes are emitted, then captured bytes, then a no-boundary marker.
// Asynchronous active-low reset clears control state; the memories need no clearing pass.
module multipart_boundary_splitter import mbs_pkg::*; #(
	parameter int MAX_BOUNDARY = MAX_BOUNDARY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_ready,
	output result_t    result,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata
);

	cmd_t  cmd;
	stat_t stat;

	mbs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	mbs_datapath #(
		.MAX_BOUNDARY (MAX_BOUNDARY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.stat         (stat)
	);

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.out_free |-> !(cmd.match_done || cmd.eos_held_emit || cmd.eos_cap_emit ||
			cmd.eos_end || (cmd.push && stat.held_full)))
		else $error("result register overwritten");

	a_idle_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !(cmd.push || cmd.capture || cmd.cap_rd || cmd.pat_write))
		else $error("datapath busy while taking a request");

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eos_end |=> stat.held_empty && !stat.cap_active)
		else $error("stream state not cleared at end of stream");

	a_match_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.match_done |=> result_valid && result.last && result.kind == KIND_BOUNDARY)
		else $error("boundary marker missing after match");

endmodule

// ----- src/mbs_ctrl.sv -----
// Controller state machine of the multipart boundary splitter.
module mbs_ctrl import mbs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (stat.action)
					ACT_LOAD: state_d = ST_IDLE;
					ACT_STREAM: begin
						if (stat.cap_path) begin
							if (!stat.finish) state_d = ST_IDLE;
							else if (!stat.mismatch_next) begin
								if (stat.out_free) state_d = ST_IDLE;
							end else state_d = ST_DRAIN_RD;
						end else if (!stat.held_full || stat.out_free) begin
							state_d = ST_IDLE;
						end
					end
					ACT_EOS: state_d = ST_EOS_HELD;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_DRAIN_RD: state_d = ST_DRAIN_PUSH;
			ST_DRAIN_PUSH: begin
				if (!stat.held_full || stat.out_free) begin
					state_d = stat.k_last ? ST_IDLE : ST_DRAIN_RD;
				end
			end
			ST_EOS_HELD: begin
				if (stat.held_empty) state_d = stat.cap_active ? ST_EOS_RD : ST_EOS_END;
			end
			ST_EOS_RD: state_d = ST_EOS_CAP;
			ST_EOS_CAP: begin
				if (stat.out_free) state_d = stat.k_last ? ST_EOS_END : ST_EOS_RD;
			end
			ST_EOS_END: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.load_item = item_valid;
			end
			ST_EXEC: begin
				case (stat.action)
					ACT_LOAD: cmd.pat_write = 1'b1;
					ACT_STREAM: begin
						if (stat.cap_path) begin
							if (!stat.finish) cmd.capture = 1'b1;
							else if (!stat.mismatch_next) cmd.match_done = stat.out_free;
							else begin
								cmd.capture = 1'b1;
								cmd.mismatch_start = 1'b1;
								cmd.k_clr = 1'b1;
							end
						end else if (!stat.held_full || stat.out_free) begin
							cmd.push = 1'b1;
							cmd.push_last = 1'b1;
						end
					end
					default: cmd = '0;
				endcase
			end
			ST_DRAIN_RD: cmd.cap_rd = 1'b1;
			ST_DRAIN_PUSH: begin
				if (!stat.held_full || stat.out_free) begin
					cmd.push = 1'b1;
					cmd.push_cap = 1'b1;
					cmd.push_last = stat.k_last;
					cmd.drain_end = stat.k_last;
					cmd.k_inc = !stat.k_last;
				end
			end
			ST_EOS_HELD: begin
				if (stat.held_empty) cmd.k_clr = 1'b1;
				else cmd.eos_held_emit = stat.out_free;
			end
			ST_EOS_RD: cmd.cap_rd = 1'b1;
			ST_EOS_CAP: begin
				if (stat.out_free) begin
					cmd.eos_cap_emit = 1'b1;
					cmd.k_inc = !stat.k_last;
				end
			end
			ST_EOS_END: cmd.eos_end = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ----- src/mbs_datapath.sv -----
// Datapath: pattern and capture memories, two-byte delay, counters and result register.
module mbs_datapath import mbs_pkg::*; #(
	parameter int MAX_BOUNDARY = MAX_BOUNDARY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	output result_t    result,
	output logic       result_valid,
	input  logic       result_ready,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	input  cmd_t       cmd,
	output stat_t      stat
);

	localparam int IDX_W = $clog2(MAX_BOUNDARY);
	localparam int CNT_W = $clog2(MAX_BOUNDARY + 1);

	logic [7:0] pat_mem [MAX_BOUNDARY];
	logic [7:0] cap_mem [MAX_BOUNDARY];

	item_t            item_q;
	logic [7:0]       pat_rdata_q;
	logic [7:0]       cap_rdata_q;
	logic [7:0]       held0_q, held1_q;
	logic [1:0]       hc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] k_q;
	logic             active_q;
	logic             mis_q;
	logic [7:0]       prev_q;
	logic [5:0]       len_q;
	result_t          out_q;
	logic             out_valid_q;

	logic [5:0]       len_clamp;
	logic [CNT_W-1:0] eff_len;
	logic [7:0]       push_src;
	logic             emit;
	result_t          emit_d;

	always_comb begin
		if (len_q == 6'd0) len_clamp = 6'd1;
		else if (len_q > 6'(MAX_BOUNDARY)) len_clamp = 6'(MAX_BOUNDARY);
		else len_clamp = len_q;
	end
	assign eff_len = CNT_W'(len_clamp);

	assign push_src = cmd.push_cap ? cap_rdata_q : item_q.in_byte;

	always_comb begin
		stat.action        = item_q.action;
		stat.cap_path      = active_q || (item_q.in_byte == CHAR_DASH &&
			(prev_q == CHAR_CR || prev_q == CHAR_LF));
		stat.finish        = ({1'b0, cnt_q} + (CNT_W + 1)'(1)) >= {1'b0, eff_len};
		stat.mismatch_next = mis_q || (pat_rdata_q != item_q.in_byte);
		stat.held_full     = (hc_q == 2'd2);
		stat.held_empty    = (hc_q == 2'd0);
		stat.out_free      = !out_valid_q || result_ready;
		stat.k_last        = (CNT_W'(k_q) + CNT_W'(1)) == cnt_q;
		stat.cap_active    = active_q;
	end

	always_comb begin
		emit = 1'b0;
		emit_d = '0;
		if (cmd.push && hc_q == 2'd2) begin
			emit = 1'b1;
			emit_d = '{kind: KIND_DATA, out_byte: held0_q, last: cmd.push_last};
		end
		if (cmd.match_done) begin
			emit = 1'b1;
			emit_d = '{kind: KIND_BOUNDARY, out_byte: 8'd0, last: 1'b1};
		end
		if (cmd.eos_held_emit) begin
			emit = 1'b1;
			emit_d = '{kind: KIND_DATA, out_byte: held0_q, last: 1'b0};
		end
		if (cmd.eos_cap_emit) begin
			emit = 1'b1;
			emit_d = '{kind: KIND_DATA, out_byte: cap_rdata_q, last: 1'b0};
		end
		if (cmd.eos_end) begin
			emit = 1'b1;
			emit_d = '{kind: KIND_NO_BOUNDARY, out_byte: 8'd0, last: 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pat_write && item_q.pattern_index < 6'(MAX_BOUNDARY)) begin
			pat_mem[item_q.pattern_index[IDX_W-1:0]] <= item_q.in_byte;
		end
		if (cmd.load_item) pat_rdata_q <= pat_mem[cnt_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) cap_mem[cnt_q[IDX_W-1:0]] <= item_q.in_byte;
		if (cmd.cap_rd) cap_rdata_q <= cap_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= item;
		if (cmd.push) begin
			case (hc_q)
				2'd0: held0_q <= push_src;
				2'd1: held1_q <= push_src;
				default: begin
					held0_q <= held1_q;
					held1_q <= push_src;
				end
			endcase
		end
		if (cmd.eos_held_emit) held0_q <= held1_q;
		if (emit) out_q <= emit_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q        <= 2'd0;
			cnt_q       <= '0;
			k_q         <= '0;
			active_q    <= 1'b0;
			mis_q       <= 1'b0;
			prev_q      <= 8'd0;
			len_q       <= LENGTH_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) len_q <= cfg_wdata;
			if (cmd.capture) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cmd.mismatch_start) begin
					active_q <= 1'b0;
					mis_q    <= 1'b0;
					prev_q   <= CHAR_DASH;
				end else begin
					mis_q    <= stat.mismatch_next;
					active_q <= 1'b1;
					prev_q   <= item_q.in_byte;
				end
			end
			if (cmd.push) begin
				if (hc_q != 2'd2) hc_q <= hc_q + 2'd1;
				if (!cmd.push_cap) prev_q <= item_q.in_byte;
			end
			if (cmd.eos_held_emit) hc_q <= hc_q - 2'd1;
			if (cmd.drain_end) cnt_q <= '0;
			if (cmd.match_done || cmd.eos_end) begin
				hc_q     <= 2'd0;
				cnt_q    <= '0;
				active_q <= 1'b0;
				mis_q    <= 1'b0;
				prev_q   <= 8'd0;
			end
			if (cmd.k_clr) k_q <= '0;
			else if (cmd.k_inc) k_q <= k_q + IDX_W'(1);
			if (emit) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

endmodule
